### rtl/fsa_pkg.sv
package fsa_pkg;

  localparam int MAX_SLOTS_DEF = 256;
  localparam int ALIGN_BYTES   = 8;
  localparam int ADDR_BITS     = 32;

  // shared adder width: covers addresses and the 32 bit zone size
  localparam int UNIT_W = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  // rounded slot size: 16 bit request plus up to 7 bytes of padding
  localparam int RND_W  = 17;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NOMEM    = 3'd1,
    STAT_NOTOWNER = 3'd2,
    STAT_TOOSMALL = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_t;

  localparam logic [1:0] REG_ZONE_ORIGIN = 2'd0;
  localparam logic [1:0] REG_ZONE_SIZE   = 2'd1;
  localparam logic [1:0] REG_SLOT_SIZE   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_SUB,
    S_INIT_WR,
    S_ALLOC_RD,
    S_ALLOC_OUT,
    S_FREE_LO,
    S_FREE_HI
  } state_t;

  typedef struct packed {
    logic              sub;
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] res;
    logic              cout;  // on subtract: set when a >= b
  } alu_rsp_t;

endpackage

### rtl/fsa_ram.sv
module fsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fsa_alu.sv
module fsa_alu (
  input  fsa_pkg::alu_req_t req,
  output fsa_pkg::alu_rsp_t rsp
);
  import fsa_pkg::*;

  logic [UNIT_W:0] sum;
  logic [UNIT_W-1:0] b_eff;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign sum   = {1'b0, req.a} + {1'b0, b_eff} + (UNIT_W+1)'(req.sub);

  assign rsp.res  = sum[UNIT_W-1:0];
  assign rsp.cout = sum[UNIT_W];

endmodule

### rtl/fixed_slot_allocator.sv
// an accepted start is answered straight from idle for a no-op, an empty-stack alloc and
// zero slot size; an alloc runs S_ALLOC_RD, S_ALLOC_OUT; a release runs S_FREE_LO (ending
// there below the zone origin), S_FREE_HI; init alternates S_INIT_SUB and S_INIT_WR per slot
// one item at a time, busy high until the result is registered; the shared adder
// does the bound checks and, per slot, one remainder subtract and one address add
// synchronous active-low reset clears the sequencer, stack count, out_valid and zone registers
// and sets the slot size to 8; the free stack memory is not cleared; results cannot be stalled by the receiver
module fixed_slot_allocator #(
  parameter int MAX_SLOTS = fsa_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_release_address,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_slot_address,
  output logic [8:0]  out_free_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import fsa_pkg::*;

  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  state_t state_r, state_nxt;

  logic [31:0]          zone_origin_r, zone_size_r;
  logic [15:0]          slot_size_r;
  logic [RND_W-1:0]     rnd_r, rnd_nxt, rnd_in;
  logic [UNIT_W-1:0]    rem_r, rem_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [ADDR_BITS-1:0] rel_r, rel_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_status_r, out_status_nxt;
  logic [31:0]          out_addr_r, out_addr_nxt;
  logic [8:0]           out_count_r, out_count_nxt;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [ADDR_BITS-1:0] ram_wdata, ram_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [ADDR_BITS-1:0] origin_a;
  logic                 at_max;

  fsa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  fsa_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (count_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign origin_a = ADDR_BITS'(zone_origin_r);
  assign at_max   = (idx_r == CW'(MAX_SLOTS));
  assign rnd_in   = RND_W'(((RND_W'(slot_size_r) + RND_W'(ALIGN_BYTES - 1)) / ALIGN_BYTES)
                    * ALIGN_BYTES);

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_address = out_addr_r;
  assign out_free_count   = out_count_r;

  // adder operand selection
  always_comb begin
    alu_req = '0;
    case (state_r)
      S_INIT_SUB: begin
        alu_req.sub = 1'b1;
        alu_req.a   = rem_r;
        alu_req.b   = UNIT_W'(rnd_r);
      end
      S_INIT_WR: begin
        alu_req.sub = 1'b0;
        alu_req.a   = UNIT_W'(addr_r);
        alu_req.b   = UNIT_W'(rnd_r);
      end
      S_FREE_LO: begin
        alu_req.sub = 1'b1;
        alu_req.a   = UNIT_W'(rel_r);
        alu_req.b   = UNIT_W'(origin_a);
      end
      S_FREE_HI: begin
        alu_req.sub = 1'b1;
        alu_req.a   = rem_r;
        alu_req.b   = UNIT_W'(zone_size_r);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_INIT:  state_nxt = (rnd_in == '0) ? S_IDLE : S_INIT_SUB;
            OP_ALLOC: state_nxt = (count_r == '0) ? S_IDLE : S_ALLOC_RD;
            OP_FREE:  state_nxt = S_FREE_LO;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_INIT_SUB:  state_nxt = (alu_rsp.cout && !at_max) ? S_INIT_WR : S_IDLE;
      S_INIT_WR:   state_nxt = S_INIT_SUB;
      S_ALLOC_RD:  state_nxt = S_ALLOC_OUT;
      S_ALLOC_OUT: state_nxt = S_IDLE;
      S_FREE_LO:   state_nxt = alu_rsp.cout ? S_FREE_HI : S_IDLE;
      S_FREE_HI:   state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    rnd_nxt        = rnd_r;
    rem_nxt        = rem_r;
    addr_nxt       = addr_r;
    rel_nxt        = rel_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = '0;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[IW-1:0];
    ram_wdata      = addr_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_INIT: begin
              rnd_nxt  = rnd_in;
              rem_nxt  = UNIT_W'(zone_size_r);
              addr_nxt = origin_a;
              idx_nxt  = '0;
              if (rnd_in == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_TOOSMALL;
              end
            end
            OP_ALLOC: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_NOMEM;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            OP_FREE: begin
              rel_nxt = ADDR_BITS'(in_release_address);
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_OK;
            end
          endcase
        end
      end
      S_INIT_SUB: begin
        if (alu_rsp.cout) begin
          if (at_max) begin
            // more slots fit than the stack holds
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_OVERFLOW;
            count_nxt      = idx_r;
          end else begin
            rem_nxt = alu_rsp.res;
          end
        end else if (idx_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_TOOSMALL;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          count_nxt      = idx_r;
        end
      end
      S_INIT_WR: begin
        ram_we   = 1'b1;
        addr_nxt = alu_rsp.res[ADDR_BITS-1:0];
        idx_nxt  = idx_r + 1'b1;
      end
      S_ALLOC_OUT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_OK;
        out_addr_nxt   = 32'(ram_rdata);
      end
      S_FREE_LO: begin
        rem_nxt = alu_rsp.res;
        if (!alu_rsp.cout) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NOTOWNER;
        end
      end
      S_FREE_HI: begin
        out_valid_nxt = 1'b1;
        if (alu_rsp.cout) begin
          // offset at or past the zone size
          out_status_nxt = STAT_NOTOWNER;
        end else if (count_r == CW'(MAX_SLOTS)) begin
          out_status_nxt = STAT_OVERFLOW;
        end else begin
          out_status_nxt = STAT_OK;
          ram_we         = 1'b1;
          ram_waddr      = count_r[IW-1:0];
          ram_wdata      = rel_r;
          count_nxt      = count_r + 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
    out_count_nxt = 9'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      zone_origin_r <= '0;
      zone_size_r   <= '0;
      slot_size_r   <= 16'd8;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ZONE_ORIGIN: zone_origin_r <= cfg_wdata;
          REG_ZONE_SIZE:   zone_size_r   <= cfg_wdata;
          REG_SLOT_SIZE:   slot_size_r   <= cfg_wdata[15:0];
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rnd_r        <= rnd_nxt;
    rem_r        <= rem_nxt;
    addr_r       <= addr_nxt;
    rel_r        <= rel_nxt;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

### tb/fixed_slot_allocator_tb.sv
module fixed_slot_allocator_tb;
  import fsa_pkg::*;

  localparam int SLOT_CAP    = MAX_SLOTS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_GOAL   = 550;

  typedef struct {
    op_t         op;
    logic [31:0] rel;
    int unsigned hold;
  } slot_cmd_t;

  typedef struct {
    status_t     status;
    logic [31:0] addr;
    logic [8:0]  count;
  } slot_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = '0;
  logic [31:0] in_release_address = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_slot_address;
  logic [8:0]  out_free_count;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  fixed_slot_allocator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_release_address (in_release_address),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_address   (out_slot_address),
    .out_free_count     (out_free_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // allocator state as the block should hold it
  logic [31:0] free_slots [SLOT_CAP];
  int unsigned slots_free = 0;
  logic [31:0] zone_base = '0;
  logic [31:0] zone_len = '0;
  logic [15:0] slot_req = 16'd8;

  slot_cmd_t    cmd_queue [$];
  slot_result_t due_replies [$];

  int unsigned pace = 0;
  int unsigned wait_count = 0;
  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned op_tally [4] = '{default: 0};
  int unsigned status_tally [5] = '{default: 0};

  function automatic slot_result_t allocator_step(op_t op, logic [31:0] rel);
    slot_result_t r;
    int unsigned rnd;
    int unsigned fit;
    logic [31:0] a;
    r.status = STAT_OK;
    r.addr = '0;
    case (op)
      OP_INIT: begin
        rnd = (32'(slot_req) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
        fit = (rnd == 0) ? 0 : zone_len / rnd;
        if (fit == 0) begin
          r.status = STAT_TOOSMALL;
        end else begin
          if (fit > SLOT_CAP) begin
            fit = SLOT_CAP;
            r.status = STAT_OVERFLOW;
          end
          // ascending fill, highest address ends on top
          a = zone_base;
          for (int i = 0; i < fit; i++) begin
            free_slots[i] = a;
            a = a + rnd[31:0];
          end
          slots_free = fit;
        end
      end
      OP_ALLOC: begin
        if (slots_free == 0) begin
          r.status = STAT_NOMEM;
        end else begin
          slots_free--;
          r.addr = free_slots[slots_free];
        end
      end
      OP_FREE: begin
        if (rel < zone_base || rel - zone_base >= zone_len) begin
          r.status = STAT_NOTOWNER;
        end else if (slots_free >= SLOT_CAP) begin
          r.status = STAT_OVERFLOW;
        end else begin
          free_slots[slots_free] = rel;
          slots_free++;
        end
      end
      default: ;
    endcase
    r.count = slots_free[8:0];
    status_tally[r.status]++;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic queue_item(op_t op, logic [31:0] rel);
    slot_cmd_t c;
    c.op = op;
    c.rel = rel;
    case (pace)
      0: c.hold = 0;
      1: c.hold = $urandom_range(0, 7);
      default: c.hold = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
    endcase
    cmd_queue.push_back(c);
    items_queued++;
  endtask

  // returns once every transfer is done and every reply is in
  task automatic drain();
    do @(posedge clk);
    while (cmd_queue.size() != 0 || start || busy || due_replies.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_zone(logic [31:0] base, logic [31:0] len, logic [15:0] req);
    drain();
    write_reg(REG_ZONE_ORIGIN, base);
    write_reg(REG_ZONE_SIZE, len);
    write_reg(REG_SLOT_SIZE, {16'h0, req});
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_index)
        REG_ZONE_ORIGIN: zone_base = cfg_wdata;
        REG_ZONE_SIZE:   zone_len = cfg_wdata;
        REG_SLOT_SIZE:   slot_req = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : driver
    slot_cmd_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      wait_count = 0;
    end else begin
      if (start && !busy) begin
        due_replies.push_back(allocator_step(op_t'(in_opcode), in_release_address));
        op_tally[in_opcode]++;
      end
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 && wait_count >= cmd_queue[0].hold) begin
          nxt = cmd_queue.pop_front();
          start <= 1'b1;
          in_opcode <= nxt.op;
          in_release_address <= nxt.rel;
          wait_count = 0;
        end else begin
          start <= 1'b0;
          if (cmd_queue.size() != 0) wait_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    slot_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (due_replies.size() == 0) begin
        report_mismatch($sformatf("reply %0d with nothing outstanding: status %0d addr %h count %0d",
                                  results_seen, out_status, out_slot_address, out_free_count));
      end else begin
        want = due_replies.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                    results_seen, out_status, want.status));
        if (out_slot_address !== want.addr)
          report_mismatch($sformatf("reply %0d slot_address %h, want %h",
                                    results_seen, out_slot_address, want.addr));
        if (out_free_count !== want.count)
          report_mismatch($sformatf("reply %0d free_count %0d, want %0d",
                                    results_seen, out_free_count, want.count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d replies outstanding",
               STALL_LIMIT, due_replies.size());
      $display("fixed_slot_allocator verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] base;
    logic [31:0] len;
    logic [31:0] rel;
    logic [15:0] req;
    int unsigned rnd;
    int unsigned fit;
    int unsigned bias;
    int unsigned pick;
    int unsigned n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty stack and a zero-size zone
    pace = 0;
    queue_item(OP_ALLOC, 32'h0);
    queue_item(OP_FREE, 32'h0);
    queue_item(OP_NONE, 32'hFFFF_FFFF);
    queue_item(OP_INIT, 32'h0);

    // zone wraps past the top of the address space, slot size rounds up
    set_zone(32'hFFFF_FFF0, 32'd40, 16'd1);
    pace = 1;
    queue_item(OP_INIT, 32'h0);
    repeat (6) queue_item(OP_ALLOC, $urandom);
    queue_item(OP_FREE, 32'hFFFF_FFF0);
    queue_item(OP_FREE, 32'h0000_0017);
    queue_item(OP_FREE, 32'hFFFF_FFFF);

    // widest slot rounds to 64k, count capped, release into a full stack
    set_zone(32'h0000_1000, 32'hFFFF_FFFF, 16'hFFFF);
    pace = 2;
    queue_item(OP_INIT, 32'h0);
    queue_item(OP_FREE, 32'h0000_1000);
    queue_item(OP_FREE, 32'h0000_0FFF);
    queue_item(OP_ALLOC, 32'h0);

    // zero slot size never fits
    set_zone(32'h0, 32'd100, 16'd0);
    queue_item(OP_INIT, 32'h0);
    queue_item(OP_NONE, 32'h0);

    // one slot at the very top address
    set_zone(32'hFFFF_FFFF, 32'd65528, 16'd65528);
    pace = 0;
    queue_item(OP_INIT, 32'h0);
    queue_item(OP_ALLOC, 32'h0);
    queue_item(OP_FREE, 32'hFFFF_FFFF);
    queue_item(OP_FREE, 32'h0);

    while (items_queued < ITEM_GOAL) begin
      case ($urandom_range(0, 3))
        0: base = 32'h0;
        1: base = $urandom;
        2: base = 32'hFFFF_FFFF - $urandom_range(0, 4095);
        default: base = $urandom_range(0, 65535) * 8;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: req = $urandom_range(1, 64);
        6, 7: req = $urandom_range(1, 65535);
        default: req = $urandom_range(65520, 65535);
      endcase
      rnd = (32'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
      case ($urandom_range(0, 9))
        7: len = 32'h0;
        8: len = $urandom;
        9: len = 32'hFFFF_FFFF;
        default: len = $urandom_range(0, 24) * rnd + $urandom_range(0, rnd - 1);
      endcase
      set_zone(base, len, req);

      fit = len / rnd;
      if (fit > SLOT_CAP) fit = SLOT_CAP;
      pace = $urandom_range(0, 2);
      bias = $urandom_range(15, 85);
      if ($urandom_range(0, 4) != 0) queue_item(OP_INIT, $urandom);
      n = $urandom_range(15, 60);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          queue_item(OP_INIT, $urandom);
        end else if (pick < 8) begin
          queue_item(OP_NONE, $urandom);
        end else if ($urandom_range(0, 99) < bias) begin
          queue_item(OP_ALLOC, $urandom);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
              rel = base + $urandom_range(0, (fit == 0) ? 0 : fit - 1) * rnd;
            5, 6: rel = base + $urandom_range(0, len - 1);
            7: rel = base - 1;
            8: rel = base + len - $urandom_range(0, 1);
            default: rel = $urandom;
          endcase
          queue_item(OP_FREE, rel);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (due_replies.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", due_replies.size()));
    $display("%0d commands over %0d zone settings: %0d init, %0d alloc, %0d release, %0d no-op",
             items_queued, settings_used, op_tally[OP_INIT], op_tally[OP_ALLOC],
             op_tally[OP_FREE], op_tally[OP_NONE]);
    $display("replies: %0d ok, %0d out of memory, %0d not owner, %0d too small, %0d overflow",
             status_tally[STAT_OK], status_tally[STAT_NOMEM], status_tally[STAT_NOTOWNER],
             status_tally[STAT_TOOSMALL], status_tally[STAT_OVERFLOW]);
    if (mismatches == 0) begin
      $display("fixed_slot_allocator verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("fixed_slot_allocator verification failed");
    end
    $finish;
  end

endmodule

### fixed_slot_allocator.f
rtl/fsa_pkg.sv
rtl/fsa_ram.sv
rtl/fsa_alu.sv
rtl/fixed_slot_allocator.sv
tb/fixed_slot_allocator_tb.sv
